@@ rtl/cgm_pkg.sv @@
// ----------------------------------------------------------------------------
// cgm_pkg
// Shared types and widths for the color gradient magnitude pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cgm_pkg;

    localparam int DER_W    = 16;              // one derivative, signed Q8.8
    localparam int PIX_W    = 6 * DER_W;       // packed input beat
    localparam int SQ_W     = 32;              // square or cross product
    localparam int TXY_W    = SQ_W + 1;        // signed cross sum
    localparam int SUM_W    = SQ_W + 1;        // gxx + gyy
    localparam int DISC_W   = 2 * SQ_W + 3;    // (gxx-gyy)^2 + 4*gxy^2
    localparam int ROOT1_W  = 34;              // isqrt of discriminant
    localparam int LAM_W    = 34;              // largest eigenvalue, Q16.16
    localparam int MAG_W    = 17;              // result, unsigned Q8.8
    localparam int OUT_TDATA_W = 24;
    localparam int MAG_MAX  = 80264;

    // first field in the highest bits
    typedef struct packed {
        logic signed [DER_W-1:0] blue_dy;
        logic signed [DER_W-1:0] blue_dx;
        logic signed [DER_W-1:0] green_dy;
        logic signed [DER_W-1:0] green_dx;
        logic signed [DER_W-1:0] red_dy;
        logic signed [DER_W-1:0] red_dx;
    } deriv_t;

    typedef struct packed {
        logic [DISC_W-1:0] disc;
        logic [SUM_W-1:0]  trace;
    } tensor_t;

endpackage

`default_nettype wire

@@ rtl/cgm_tensor.sv @@
// ----------------------------------------------------------------------------
// cgm_tensor
// Five-stage front end: products, tensor sums, difference and magnitude,
// squares, and the eigenvalue discriminant.
// ----------------------------------------------------------------------------
`default_nettype none

module cgm_tensor
    import cgm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire deriv_t  in_pix,
    output logic         out_valid,
    output tensor_t      out_tensor
);

    logic [4:0] valid_reg;

    // stage 1: products
    logic signed [SQ_W-1:0] rxx_next, gxx_next, bxx_next;
    logic signed [SQ_W-1:0] ryy_next, gyy_next, byy_next;
    logic signed [SQ_W-1:0] rxy_next, gxy_next, bxy_next;
    logic [SQ_W-1:0] rxx_reg, gxx_reg, bxx_reg, ryy_reg, gyy_reg, byy_reg;
    logic [SQ_W-1:0] rxy_reg, gxy_reg, bxy_reg;

    // stage 2: tensor entries
    logic [SQ_W-1:0]         txx_next, tyy_next, txx_reg, tyy_reg;
    logic signed [TXY_W-1:0] txy_next, txy_reg;

    // stage 3: |gxx-gyy|, |gxy|, trace
    logic [SQ_W-1:0]  diff_next, cm_next, diff_reg, cm_reg;
    logic [TXY_W-1:0] txy_neg;
    logic [SUM_W-1:0] tr3_next, tr3_reg;

    // stage 4: squares
    logic [2*SQ_W-1:0] diff2_next, c2_next, diff2_reg, c2_reg;
    logic [SUM_W-1:0]  tr4_reg;

    // stage 5: discriminant
    logic [DISC_W-1:0] disc_next, disc_reg;
    logic [SUM_W-1:0]  tr5_reg;

    assign rxx_next = in_pix.red_dx   * in_pix.red_dx;
    assign gxx_next = in_pix.green_dx * in_pix.green_dx;
    assign bxx_next = in_pix.blue_dx  * in_pix.blue_dx;
    assign ryy_next = in_pix.red_dy   * in_pix.red_dy;
    assign gyy_next = in_pix.green_dy * in_pix.green_dy;
    assign byy_next = in_pix.blue_dy  * in_pix.blue_dy;
    assign rxy_next = in_pix.red_dx   * in_pix.red_dy;
    assign gxy_next = in_pix.green_dx * in_pix.green_dy;
    assign bxy_next = in_pix.blue_dx  * in_pix.blue_dy;

    assign txx_next = rxx_reg + gxx_reg + bxx_reg;
    assign tyy_next = ryy_reg + gyy_reg + byy_reg;
    assign txy_next = $signed({rxy_reg[SQ_W-1], rxy_reg})
                    + $signed({gxy_reg[SQ_W-1], gxy_reg})
                    + $signed({bxy_reg[SQ_W-1], bxy_reg});

    assign diff_next = (txx_reg >= tyy_reg) ? (txx_reg - tyy_reg) : (tyy_reg - txx_reg);
    assign txy_neg   = TXY_W'(0) - txy_reg;
    assign cm_next   = txy_reg[TXY_W-1] ? txy_neg[SQ_W-1:0] : txy_reg[SQ_W-1:0];
    assign tr3_next  = {1'b0, txx_reg} + {1'b0, tyy_reg};

    assign diff2_next = diff_reg * diff_reg;
    assign c2_next    = cm_reg * cm_reg;

    assign disc_next = {3'b000, diff2_reg} + {1'b0, c2_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rxx_reg   <= rxx_next;
            gxx_reg   <= gxx_next;
            bxx_reg   <= bxx_next;
            ryy_reg   <= ryy_next;
            gyy_reg   <= gyy_next;
            byy_reg   <= byy_next;
            rxy_reg   <= rxy_next;
            gxy_reg   <= gxy_next;
            bxy_reg   <= bxy_next;
            txx_reg   <= txx_next;
            tyy_reg   <= tyy_next;
            txy_reg   <= txy_next;
            diff_reg  <= diff_next;
            cm_reg    <= cm_next;
            tr3_reg   <= tr3_next;
            diff2_reg <= diff2_next;
            c2_reg    <= c2_next;
            tr4_reg   <= tr3_reg;
            disc_reg  <= disc_next;
            tr5_reg   <= tr4_reg;
        end
    end

    assign out_valid        = valid_reg[4];
    assign out_tensor.disc  = disc_reg;
    assign out_tensor.trace = tr5_reg;

endmodule

`default_nettype wire

@@ rtl/cgm_isqrt.sv @@
// ----------------------------------------------------------------------------
// cgm_isqrt
// Pipelined floored integer square root, one result bit per stage
// (restoring digit-by-digit method).
// ----------------------------------------------------------------------------
`default_nettype none

module cgm_isqrt #(
    parameter int RES_W = 34
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [2*RES_W-1:0] in_rad,
    output logic                    out_valid,
    output logic [RES_W-1:0]        out_root
);

    localparam int RAD_W = 2 * RES_W;
    localparam int REM_W = RES_W + 2;

    logic [RES_W-1:0] valid_reg;
    logic [REM_W-1:0] rem_reg  [RES_W];
    logic [RES_W-1:0] root_reg [RES_W];
    logic [RAD_W-1:0] rad_reg  [RES_W];

    genvar i;
    generate
        for (i = 0; i < RES_W; i++) begin : g_stage
            logic             valid_in;
            logic [REM_W-1:0] rem_in;
            logic [RES_W-1:0] root_in;
            logic [RAD_W-1:0] rad_in;
            logic [REM_W-1:0] cur, trial, rem_next;
            logic [RES_W-1:0] root_next;
            logic             ge;

            if (i == 0) begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = '0;
                assign root_in  = '0;
                assign rad_in   = in_rad;
            end else begin : g_rest
                assign valid_in = valid_reg[i-1];
                assign rem_in   = rem_reg[i-1];
                assign root_in  = root_reg[i-1];
                assign rad_in   = rad_reg[i-1];
            end

            // bring down two radicand bits, try root*4+1
            assign cur       = {rem_in[RES_W-1:0], rad_in[RAD_W-1 -: 2]};
            assign trial     = {root_in, 2'b01};
            assign ge        = (cur >= trial);
            assign rem_next  = ge ? (cur - trial) : cur;
            assign root_next = {root_in[RES_W-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (en) begin
                    valid_reg[i] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                    rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[RES_W-1];
    assign out_root  = root_reg[RES_W-1];

endmodule

`default_nettype wire

@@ rtl/cgm_skid.sv @@
// ----------------------------------------------------------------------------
// cgm_skid
// Output register with a skid stage; ready toward the pipeline is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cgm_skid
    import cgm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [MAG_W-1:0] in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic [MAG_W-1:0]      out_data,
    input  wire logic             out_ready
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [MAG_W-1:0] out_data_reg, out_data_next;
    logic [MAG_W-1:0] skid_data_reg, skid_data_next;
    logic             in_take, out_free;

    assign in_ready = !skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = in_take;
                out_data_next   = in_data;
            end
        end else if (in_take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/color_gradient_magnitude_top.sv @@
// ----------------------------------------------------------------------------
// color_gradient_magnitude_top
// Di Zenzo color gradient magnitude: sqrt of the largest structure tensor
// eigenvalue from the x/y derivatives of R, G and B, Q8.8 in and out.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while s_tready is high and returns one result
// beat per pixel, in order. Between input accept and m_tvalid lie 5 tensor
// stages, 34 stages of the discriminant square root (one root bit per stage),
// one eigenvalue stage, 17 stages of the final square root and the output
// register. The whole pipeline advances on one enable taken from a registered
// skid stage, so s_tready drops only after two results wait at the output.
`default_nettype none

module color_gradient_magnitude_top
    import cgm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // red_dx, red_dy, green_dx, green_dy, blue_dx, blue_dy (16 bits each)
    input  wire logic [PIX_W-1:0]       s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // gradient_mag [16:0], zeros above
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic             en;
    deriv_t           pix;
    logic             ten_valid;
    tensor_t          ten;
    logic             root1_valid;
    logic [ROOT1_W-1:0] root1;
    logic [SUM_W-1:0] trace_dly_reg [ROOT1_W];
    logic [SUM_W+1:0] lam_sum;
    logic             lam_valid_reg;
    logic [LAM_W-1:0] lam_reg;
    logic             mag_valid;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] mag_out;

    assign pix      = deriv_t'(s_tdata);
    assign s_tready = en;

    cgm_tensor u_tensor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_pix     (pix),
        .out_valid  (ten_valid),
        .out_tensor (ten)
    );

    cgm_isqrt #(
        .RES_W (ROOT1_W)
    ) u_isqrt_disc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ten_valid),
        .in_rad    ({1'b0, ten.disc}),
        .out_valid (root1_valid),
        .out_root  (root1)
    );

    // trace rides alongside the discriminant root
    always_ff @(posedge aclk) begin
        if (en) begin
            trace_dly_reg[0] <= ten.trace;
            for (int k = 1; k < ROOT1_W; k++) begin
                trace_dly_reg[k] <= trace_dly_reg[k-1];
            end
        end
    end

    assign lam_sum = {2'b00, trace_dly_reg[ROOT1_W-1]} + {1'b0, root1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lam_valid_reg <= 1'b0;
        end else if (en) begin
            lam_valid_reg <= root1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lam_reg <= lam_sum[LAM_W:1];
        end
    end

    cgm_isqrt #(
        .RES_W (MAG_W)
    ) u_isqrt_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (lam_valid_reg),
        .in_rad    (lam_reg),
        .out_valid (mag_valid),
        .out_root  (mag)
    );

    cgm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mag_valid),
        .in_data   (mag),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_data  (mag_out),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(OUT_TDATA_W-MAG_W){1'b0}}, mag_out};

    // skid full implies a result is on offer
    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // skid stays full until the output is taken
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && !m_tready |=> !s_tready)
        else $error("skid drained without output handshake");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[MAG_W-1:0] <= MAG_W'(MAG_MAX)))
        else $error("gradient magnitude out of range");

endmodule

`default_nettype wire
